@@ rtl/isq_pkg.sv @@
// Package for the two-word integer square root block.
// Holds word widths, the step-unit result type and shared constants; no dependencies.
package isq_pkg;

  localparam int unsigned WORD_W = 64;
  localparam int unsigned ROOT_W = 64;
  localparam int unsigned RAD_W  = 2 * ROOT_W;
  localparam int unsigned REM_W  = ROOT_W + 3;
  localparam int unsigned CNT_W  = $clog2(ROOT_W);

  localparam logic [ROOT_W-1:0] NORM_MIN = ROOT_W'(1) << (ROOT_W - 2);
  localparam logic [CNT_W-1:0]  CNT_LAST = CNT_W'(ROOT_W - 1);

  typedef struct packed {
    logic             ge;
    logic [REM_W-1:0] diff;
  } isq_step_t;

endpackage

@@ rtl/double_word_isqrt_with_remainder.sv @@
// Two-word integer square root with remainder: top level with sequencer.
// Depends on isq_pkg and isq_sub_unit.
//
// The block takes a radicand N = value_high * 2^64 + value_low and returns
// root = floor(sqrt(N)) together with N - root*root, split into rem_low (the
// low 64 bits) and rem_carry (bit 64). The upper word must be at least 2^62;
// otherwise the item completes with bad_input set and all other fields zero.
// A restoring digit recurrence settles one root bit per cycle through a single
// shared subtract-and-compare unit once the item is loaded, and the result
// appears on the output register in the cycle after the last step; an
// unnormalized item skips the recurrence and finishes once the output register
// is free. The input side accepts a new item whenever the recurrence is idle,
// and a finished result waiting in the output register does not block that
// acceptance; the last step of the next item stalls until the register is free.
module double_word_isqrt_with_remainder (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [isq_pkg::WORD_W-1:0] value_high_i,
  input  logic [isq_pkg::WORD_W-1:0] value_low_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [isq_pkg::WORD_W-1:0] root_o,
  output logic [isq_pkg::WORD_W-1:0] rem_low_o,
  output logic                       rem_carry_o,
  output logic                       bad_input_o
);
  import isq_pkg::*;

  // Working state of the recurrence.
  logic                 busy_q, busy_d;
  logic                 bad_q, bad_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic [RAD_W-1:0]     rad_q, rad_d;
  logic [REM_W-1:0]     rem_q, rem_d;
  logic [ROOT_W-1:0]    s_q, s_d;

  // Output register.
  logic                 out_valid_q, out_valid_d;
  logic [ROOT_W-1:0]    root_q, root_d;
  logic [ROOT_W-1:0]    rem_low_q, rem_low_d;
  logic                 rem_carry_q, rem_carry_d;
  logic                 bad_out_q, bad_out_d;

  logic [ROOT_W-1:0]    hi_word;
  logic [ROOT_W-1:0]    lo_word;
  logic                 in_fire;
  logic                 out_fire;
  logic                 slot_free;
  logic                 last_step;
  logic                 step_en;
  logic                 finish;
  logic [REM_W-1:0]     rem_shift;
  logic [REM_W-1:0]     trial;
  isq_step_t            step;
  logic [REM_W-1:0]     rem_next;
  logic [ROOT_W-1:0]    s_next;

  // Bits above the limb width are ignored.
  assign hi_word = value_high_i[ROOT_W-1:0];
  assign lo_word = value_low_i[ROOT_W-1:0];

  assign in_ready_o = ~busy_q;
  assign in_fire    = in_valid_i & ~busy_q;
  assign out_fire   = out_valid_q & out_ready_i;
  assign slot_free  = ~out_valid_q | out_ready_i;

  // Bring down the next two radicand bits; the trial value is 4s + 1.
  assign rem_shift = {rem_q[REM_W-3:0], rad_q[RAD_W-1 -: 2]};
  assign trial     = REM_W'({s_q, 2'b01});

  isq_sub_unit u_sub (
    .minuend_i    (rem_shift),
    .subtrahend_i (trial),
    .result_o     (step)
  );

  assign rem_next = step.ge ? step.diff : rem_shift;
  assign s_next   = {s_q[ROOT_W-2:0], step.ge};

  // The last step, and a rejected item, need the output register free.
  assign last_step = (cnt_q == '0);
  assign step_en   = busy_q & ~bad_q & (~last_step | slot_free);
  assign finish    = busy_q & slot_free & (bad_q | last_step);

  always_comb begin
    busy_d      = busy_q;
    bad_d       = bad_q;
    cnt_d       = cnt_q;
    rad_d       = rad_q;
    rem_d       = rem_q;
    s_d         = s_q;
    out_valid_d = out_valid_q;
    root_d      = root_q;
    rem_low_d   = rem_low_q;
    rem_carry_d = rem_carry_q;
    bad_out_d   = bad_out_q;

    // Drop the delivered result first; a finishing item may refill the slot.
    if (out_fire) begin
      out_valid_d = 1'b0;
    end

    if (in_fire) begin
      busy_d = 1'b1;
      bad_d  = (hi_word < NORM_MIN);
      cnt_d  = CNT_LAST;
      rad_d  = {hi_word, lo_word};
      rem_d  = '0;
      s_d    = '0;
    end else if (step_en) begin
      rad_d = {rad_q[RAD_W-3:0], 2'b00};
      rem_d = rem_next;
      s_d   = s_next;
      cnt_d = cnt_q - CNT_W'(1);
    end

    if (finish) begin
      busy_d      = 1'b0;
      out_valid_d = 1'b1;
      if (bad_q) begin
        root_d      = '0;
        rem_low_d   = '0;
        rem_carry_d = 1'b0;
        bad_out_d   = 1'b1;
      end else begin
        root_d      = s_next;
        rem_low_d   = rem_next[ROOT_W-1:0];
        rem_carry_d = rem_next[ROOT_W];
        bad_out_d   = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload and datapath registers carry no reset.
  always_ff @(posedge clk_i) begin
    bad_q       <= bad_d;
    cnt_q       <= cnt_d;
    rad_q       <= rad_d;
    rem_q       <= rem_d;
    s_q         <= s_d;
    root_q      <= root_d;
    rem_low_q   <= rem_low_d;
    rem_carry_q <= rem_carry_d;
    bad_out_q   <= bad_out_d;
  end

  assign out_valid_o = out_valid_q;
  assign root_o      = WORD_W'(root_q);
  assign rem_low_o   = WORD_W'(rem_low_q);
  assign rem_carry_o = rem_carry_q;
  assign bad_input_o = bad_out_q;

endmodule

@@ rtl/isq_sub_unit.sv @@
// Shared subtract-and-compare unit used once per root bit.
// Depends on isq_pkg.
module isq_sub_unit (
  input  logic [isq_pkg::REM_W-1:0] minuend_i,
  input  logic [isq_pkg::REM_W-1:0] subtrahend_i,
  output isq_pkg::isq_step_t        result_o
);
  import isq_pkg::*;

  logic [REM_W:0] wide_diff;

  // The top bit of the widened difference is the borrow.
  assign wide_diff     = {1'b0, minuend_i} - {1'b0, subtrahend_i};
  assign result_o.diff = wide_diff[REM_W-1:0];
  assign result_o.ge   = ~wide_diff[REM_W];

endmodule
